FILE: rtl/lcpg_pkg.sv
`default_nettype none

package lcpg_pkg;

    localparam int PIXEL_WIDTH_DEFAULT = 16;
    localparam int LOG_WIDTH_DEFAULT   = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_AMOUNT               = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_LOG_LEVEL      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_LOG_RECIPROCAL = 2'd2;

    localparam int AMOUNT_W = 15;
    localparam int RECIP_W  = 16;
    localparam logic signed [AMOUNT_W-1:0] AMOUNT_RESET = 15'sd4096;
    localparam logic signed [RECIP_W-1:0]  RECIP_RESET  = 16'sd10240;

    // boost, unsigned Q12
    localparam int BOOST_W = 13;
    localparam logic [BOOST_W-1:0] ONE_Q12       = 13'd4096;
    localparam logic [BOOST_W-1:0] BOOST_MAX_Q12 = 13'd6144;

    // exponent in Q24, clamped to +/-64.0
    localparam int E_W         = 32;
    localparam int E_LIMIT_Q24 = 1 << 30;

    localparam int L2T_W = 31;
    localparam logic signed [L2T_W-1:0] LOG2_10_Q28 = 31'sd891723283;

    // log2 of gain split into integer and fraction parts
    localparam int I_W    = 11;
    localparam int F_W    = 31;
    localparam int P_W    = 32;
    localparam int GAIN_W = 32;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    typedef logic signed [P_W-1:0] poly_t;

    localparam int HORNER_STEPS = 5;
    localparam poly_t C5_Q30 = 32'sd1431680;
    localparam poly_t HORNER_COEF [HORNER_STEPS] = '{
        32'sd10327388,
        32'sd59597083,
        32'sd257941248,
        32'sd744261118,
        32'sd1073741824
    };

    // pipeline layout
    localparam int PIPE_STAGES = 13;
    localparam int EXP_FIRST   = 6;
    localparam int EXP_STAGES  = HORNER_STEPS + 1;

endpackage

`default_nettype wire

FILE: rtl/lcpg_if.sv
`default_nettype none

interface lcpg_pixel_if #(
    parameter int LOG_WIDTH   = lcpg_pkg::LOG_WIDTH_DEFAULT,
    parameter int PIXEL_WIDTH = lcpg_pkg::PIXEL_WIDTH_DEFAULT
);
    logic                        valid;
    logic                        ready;
    logic signed [LOG_WIDTH-1:0] log_lumi;
    logic signed [LOG_WIDTH-1:0] blurred_log_lumi;
    logic [PIXEL_WIDTH-1:0]      red_in;
    logic [PIXEL_WIDTH-1:0]      green_in;
    logic [PIXEL_WIDTH-1:0]      blue_in;

    modport source (
        output valid, log_lumi, blurred_log_lumi, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, log_lumi, blurred_log_lumi, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface lcpg_result_if #(
    parameter int PIXEL_WIDTH = lcpg_pkg::PIXEL_WIDTH_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic [PIXEL_WIDTH-1:0] red_out;
    logic [PIXEL_WIDTH-1:0] green_out;
    logic [PIXEL_WIDTH-1:0] blue_out;
    logic                   clipped;

    modport source (
        output valid, red_out, green_out, blue_out, clipped,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, clipped,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/lcpg_exp2.sv
`default_nettype none

// 2^(i + f): five Horner steps for 2^f, one stage per step, then scaling
// by 2^i into unsigned Q16.16 with saturation.
module lcpg_exp2 (
    input  wire logic                                  clk,
    input  wire logic [lcpg_pkg::EXP_STAGES-1:0]       en,
    input  wire logic signed [lcpg_pkg::I_W-1:0]       i_in,
    input  wire logic signed [lcpg_pkg::F_W-1:0]       f_in,
    output logic [lcpg_pkg::GAIN_W-1:0]                gain,
    output logic                                       gain_clip
);
    localparam int STEPS  = lcpg_pkg::HORNER_STEPS;
    localparam int P_W    = lcpg_pkg::P_W;
    localparam int F_W    = lcpg_pkg::F_W;
    localparam int I_W    = lcpg_pkg::I_W;
    localparam int GAIN_W = lcpg_pkg::GAIN_W;
    localparam int MPW    = P_W + F_W;
    localparam int SW     = MPW - 30;
    localparam int GW     = P_W + 2;
    localparam int RS_W   = $clog2(GAIN_W) + 1;

    localparam logic signed [I_W-1:0] I_CLIP   = I_W'(17);
    localparam logic signed [I_W-1:0] I_UNITY  = I_W'(14);
    localparam logic signed [I_W-1:0] RS_LIMIT = I_W'(GAIN_W);

    lcpg_pkg::poly_t           p_reg [STEPS];
    lcpg_pkg::poly_t           p_next [STEPS];
    logic signed [F_W-1:0]     f_reg [STEPS-1];
    logic signed [I_W-1:0]     i_reg [STEPS];
    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic                      clip_reg, clip_next;

    always_comb
    begin
        logic signed [P_W-1:0] a;
        logic signed [F_W-1:0] b;
        logic signed [MPW-1:0] prod;
        logic signed [SW-1:0]  acc;
        for (int s = 0; s < STEPS; s++)
        begin
            a = (s == 0) ? lcpg_pkg::C5_Q30 : p_reg[(s == 0) ? 0 : s - 1];
            b = (s == 0) ? f_in : f_reg[(s == 0) ? 0 : s - 1];
            prod = MPW'(a) * MPW'(b);
            acc = $signed(prod[MPW-1:30]) + SW'(lcpg_pkg::HORNER_COEF[s]);
            p_next[s] = P_W'(acc);
        end
    end

    always_comb
    begin
        logic signed [I_W-1:0] i;
        logic signed [I_W-1:0] up_sh;
        logic signed [I_W-1:0] rs_full;
        logic [RS_W-1:0]       rs;
        logic [GW-1:0]         mag;
        logic [GW-1:0]         up;
        logic [GW-1:0]         rsum;
        i       = i_reg[STEPS-1];
        mag     = GW'(p_reg[STEPS-1][P_W-2:0]);
        up_sh   = i - I_UNITY;
        rs_full = I_UNITY - i;
        rs      = rs_full[RS_W-1:0];
        up      = mag << up_sh[1:0];
        rsum    = mag + (GW'(1) << (rs - RS_W'(1)));
        clip_next = 1'b0;
        if (i > I_CLIP)
        begin
            gain_next = lcpg_pkg::GAIN_MAX;
            clip_next = 1'b1;
        end
        else if (i >= I_UNITY)
        begin
            if (up > GW'(lcpg_pkg::GAIN_MAX))
            begin
                gain_next = lcpg_pkg::GAIN_MAX;
                clip_next = 1'b1;
            end
            else
            begin
                gain_next = up[GAIN_W-1:0];
            end
        end
        else if (rs_full > RS_LIMIT)
        begin
            // far below unity: rounds to zero
            gain_next = '0;
        end
        else
        begin
            gain_next = GAIN_W'(rsum >> rs);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg[0] <= p_next[0];
            f_reg[0] <= f_in;
            i_reg[0] <= i_in;
        end
        for (int s = 1; s < STEPS; s++)
        begin
            if (en[s])
            begin
                p_reg[s] <= p_next[s];
                i_reg[s] <= i_reg[s-1];
                if (s < STEPS - 1)
                begin
                    f_reg[s] <= f_reg[s-1];
                end
            end
        end
        if (en[STEPS])
        begin
            gain_reg <= gain_next;
            clip_reg <= clip_next;
        end
    end

    assign gain      = gain_reg;
    assign gain_clip = clip_reg;

endmodule

`default_nettype wire

FILE: rtl/local_contrast_pixel_gain.sv
// Throughput: one pixel per cycle while the output is not stalled; 13 register
// stages, each with its own valid bit and enable, so a stall fills bubbles
// before it holds the input back. Reset (rst_n low, asynchronous) clears all
// valid bits and restores amount and white_log_reciprocal to their defaults.
`default_nettype none

module local_contrast_pixel_gain #(
    parameter int PIXEL_WIDTH = lcpg_pkg::PIXEL_WIDTH_DEFAULT,
    parameter int LOG_WIDTH   = lcpg_pkg::LOG_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [lcpg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lcpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    lcpg_pixel_if.sink                              pixel,
    lcpg_result_if.source                           result
);
    localparam int N      = lcpg_pkg::PIPE_STAGES;
    localparam int XF     = lcpg_pkg::EXP_FIRST;
    localparam int XN     = lcpg_pkg::EXP_STAGES;
    localparam int PW     = PIXEL_WIDTH;
    localparam int LW     = LOG_WIDTH;
    localparam int DW     = LW + 1;
    localparam int LRW    = LW + 16;
    localparam int BSW    = LRW + 1;
    localparam int MW     = LW + 30;
    localparam int E_W    = lcpg_pkg::E_W;
    localparam int TPW    = E_W + lcpg_pkg::L2T_W;
    localparam int TW     = TPW - 22;
    localparam int I_W    = lcpg_pkg::I_W;
    localparam int F_W    = lcpg_pkg::F_W;
    localparam int BW     = lcpg_pkg::BOOST_W;
    localparam int GAIN_W = lcpg_pkg::GAIN_W;
    localparam int CPW    = PW + GAIN_W;
    localparam int VW     = PW + 16;

    localparam logic signed [MW-1:0] E_HI = MW'(lcpg_pkg::E_LIMIT_Q24);
    localparam logic signed [MW-1:0] E_LO = -E_HI;

    // configuration
    logic signed [lcpg_pkg::AMOUNT_W-1:0] amount_reg;
    logic signed [lcpg_pkg::RECIP_W-1:0]  recip_reg;

    // pipeline control
    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    // payload
    logic [3*PW-1:0]        px_reg [N-1];
    logic signed [DW-1:0]   delta_reg, delta_next;
    logic signed [LRW-1:0]  lr_reg, lr_next;
    logic signed [LRW-1:0]  da_reg, da_next;
    logic signed [LRW-1:0]  da1_reg;
    logic [BW-1:0]          boost_reg, boost_next;
    logic signed [MW-1:0]   m_reg, m_next;
    logic signed [E_W-1:0]  e_reg, e_next;
    logic signed [TPW-1:0]  tp_reg, tp_next;
    logic signed [I_W-1:0]  i_reg, i_next;
    logic signed [F_W-1:0]  f_reg, f_next;
    logic [GAIN_W-1:0]      gain;
    logic                   gain_clip;
    logic [PW-1:0]          ch_next [3];
    logic                   clip_next;
    logic [PW-1:0]          ch_reg [3];
    logic                   clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amount_reg <= lcpg_pkg::AMOUNT_RESET;
            recip_reg  <= lcpg_pkg::RECIP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lcpg_pkg::REG_AMOUNT:
                    amount_reg <= cfg_data[lcpg_pkg::AMOUNT_W-1:0];
                lcpg_pkg::REG_WHITE_LOG_LEVEL:
                    ; // software derives the reciprocal; no datapath use
                lcpg_pkg::REG_WHITE_LOG_RECIPROCAL:
                    recip_reg <= cfg_data[lcpg_pkg::RECIP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // a stage may load when it is empty or the one after it loads
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || result.ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign pixel.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= pixel.valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0: detail and the two products on the raw logs
    always_comb
    begin
        delta_next = DW'(pixel.log_lumi) - DW'(pixel.blurred_log_lumi);
        lr_next    = LRW'(pixel.blurred_log_lumi) * LRW'(recip_reg);
        da_next    = LRW'(delta_next) * LRW'(amount_reg);
    end

    // stage 1: highlight-aware boost
    always_comb
    begin
        logic signed [LRW-1:0] ratio;
        logic signed [BSW-1:0] bsum;
        logic                  amt_pos;
        ratio   = lr_reg >>> 8;
        amt_pos = !amount_reg[lcpg_pkg::AMOUNT_W-1] && (|amount_reg);
        if (delta_reg[DW-1])
        begin
            bsum = BSW'($signed({1'b0, lcpg_pkg::ONE_Q12})) + BSW'(ratio);
        end
        else
        begin
            bsum = BSW'($signed({1'b0, lcpg_pkg::ONE_Q12})) - BSW'(ratio);
        end
        if (!amt_pos || !(|delta_reg))
        begin
            boost_next = lcpg_pkg::ONE_Q12;
        end
        else if (bsum[BSW-1])
        begin
            boost_next = '0;
        end
        else if (bsum > BSW'($signed({1'b0, lcpg_pkg::BOOST_MAX_Q12})))
        begin
            boost_next = lcpg_pkg::BOOST_MAX_Q12;
        end
        else
        begin
            boost_next = bsum[BW-1:0];
        end
    end

    // stage 2: full exponent product
    assign m_next = MW'(da1_reg) * MW'($signed({1'b0, boost_reg}));

    // stage 3: to Q24 and clamp
    always_comb
    begin
        logic signed [MW-1:0] es;
        es = m_reg >>> 11;
        if (es > E_HI)
        begin
            e_next = E_W'(E_HI);
        end
        else if (es < E_LO)
        begin
            e_next = E_W'(E_LO);
        end
        else
        begin
            e_next = E_W'(es);
        end
    end

    // stage 4: change of base to log2
    assign tp_next = TPW'(e_reg) * TPW'(lcpg_pkg::LOG2_10_Q28);

    // stage 5: round to nearest integer, keep the fraction in [-0.5, 0.5)
    always_comb
    begin
        logic [TW-1:0] ti;
        ti     = tp_reg[TPW-1:22] + TW'(1 << 29);
        i_next = ti[TW-1:30];
        f_next = F_W'({1'b0, ti[29:0]}) - F_W'(1 << 29);
    end

    lcpg_exp2 u_exp2 (
        .clk       (clk),
        .en        (en[XF+XN-1:XF]),
        .i_in      (i_reg),
        .f_in      (f_reg),
        .gain      (gain),
        .gain_clip (gain_clip)
    );

    // last stage: scale channels, round half up, saturate
    always_comb
    begin
        logic [CPW-1:0] prod;
        logic [VW-1:0]  v;
        clip_next = gain_clip;
        for (int c = 0; c < 3; c++)
        begin
            prod = CPW'(px_reg[N-2][c*PW +: PW]) * CPW'(gain) + CPW'(1 << 15);
            v    = prod[CPW-1:16];
            if (|v[VW-1:PW])
            begin
                ch_next[c] = '1;
                clip_next  = 1'b1;
            end
            else
            begin
                ch_next[c] = v[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg[0] <= {pixel.blue_in, pixel.green_in, pixel.red_in};
            delta_reg <= delta_next;
            lr_reg    <= lr_next;
            da_reg    <= da_next;
        end
        for (int k = 1; k < N - 1; k++)
        begin
            if (en[k])
            begin
                px_reg[k] <= px_reg[k-1];
            end
        end
        if (en[1])
        begin
            boost_reg <= boost_next;
            da1_reg   <= da_reg;
        end
        if (en[2])
        begin
            m_reg <= m_next;
        end
        if (en[3])
        begin
            e_reg <= e_next;
        end
        if (en[4])
        begin
            tp_reg <= tp_next;
        end
        if (en[5])
        begin
            i_reg <= i_next;
            f_reg <= f_next;
        end
        if (en[N-1])
        begin
            ch_reg   <= ch_next;
            clip_reg <= clip_next;
        end
    end

    assign result.valid     = v_reg[N-1];
    assign result.red_out   = ch_reg[0];
    assign result.green_out = ch_reg[1];
    assign result.blue_out  = ch_reg[2];
    assign result.clipped   = clip_reg;

endmodule

`default_nettype wire

FILE: rtl/lcpg_checker.sv
`default_nettype none

module lcpg_checker #(
    parameter int PIXEL_WIDTH = lcpg_pkg::PIXEL_WIDTH_DEFAULT
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   pixel_valid,
    input wire logic                   pixel_ready,
    input wire logic                   result_valid,
    input wire logic                   result_ready,
    input wire logic [3*PIXEL_WIDTH:0] result_payload
);

    // a result that is not taken stays, unchanged
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_payload))
    ) else $error("result transaction changed while stalled");

    // input is held back only when every stage is full and the output stalls
    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> (result_valid && !result_ready)
    ) else $error("input refused while pipeline can advance");

    // nothing comes out of a pipeline that reset has just emptied
    a_reset_empty: assert property (
        @(posedge clk)
        !rst_n |=> !result_valid
    ) else $error("result valid right after reset");

    // a draining output never blocks a new pixel
    a_drain_accepts: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_ready && pixel_valid) |-> pixel_ready
    ) else $error("pixel refused while output drains");

endmodule

bind local_contrast_pixel_gain lcpg_checker #(
    .PIXEL_WIDTH (PIXEL_WIDTH)
) u_lcpg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pixel_valid    (pixel.valid),
    .pixel_ready    (pixel.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload ({result.clipped, result.blue_out, result.green_out, result.red_out})
);

`default_nettype wire
